>>> hdl/chst_pkg.sv
// Shared types and constants for the chained string hash table.
// No dependencies; compile first.
`default_nettype none

package chst_pkg;

  localparam int BYTE_W    = 8;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 5;
  localparam int KIND_W    = 2;
  localparam int HASH_W    = 32;
  localparam int BKT_OUT_W = 10;
  localparam int KEY_BYTES = 2 * KEY_W / BYTE_W;

  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_SEARCH = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;

endpackage

`default_nettype wire

>>> hdl/chst_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on chst_pkg.
`default_nettype none

interface chst_req_if;
  logic                          valid;
  logic                          ready;
  logic [chst_pkg::KIND_W-1:0]   kind;
  logic [chst_pkg::KEY_W-1:0]    key_low;
  logic [chst_pkg::KEY_W-1:0]    key_high;
  logic [chst_pkg::LEN_W-1:0]    key_length;

  modport source (output valid, kind, key_low, key_high, key_length, input ready);
  modport sink   (input valid, kind, key_low, key_high, key_length, output ready);
endinterface

interface chst_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic                            stored;
  logic                            bucket_full;
  logic [chst_pkg::BKT_OUT_W-1:0]  bucket;
  logic [chst_pkg::LEN_W-1:0]      longest_length;
  logic [chst_pkg::BKT_OUT_W-1:0]  longest_bucket;
  logic [chst_pkg::BKT_OUT_W-1:0]  last_bucket;

  modport source (output valid, found, stored, bucket_full, bucket, longest_length,
                  longest_bucket, last_bucket, input ready);
  modport sink   (input valid, found, stored, bucket_full, bucket, longest_length,
                  longest_bucket, last_bucket, output ready);
endinterface

`default_nettype wire

>>> hdl/chst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module chst_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/chst_hash.sv
// Iterative djb2 hash and bucket reduction: one key byte per cycle through a
// shared shift-add, then a reciprocal-multiply remainder through quotient, remainder and fix-up steps. Uses chst_pkg.
`default_nettype none

module chst_hash #(
  parameter int  BUCKETS = 1024,
  localparam int BKT_W   = $clog2(BUCKETS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [chst_pkg::KEY_W-1:0]      key_low,
  input  wire logic [chst_pkg::KEY_W-1:0]      key_high,
  input  wire logic [chst_pkg::LEN_W-1:0]      key_len,
  output logic                                 done,
  output logic      [BKT_W-1:0]                bucket
);

  import chst_pkg::*;

  localparam int RW     = BKT_W + 1;
  localparam int PROD_W = 2 * HASH_W;
  // floor(2^32 / BUCKETS); the quotient taken from it is low by at most one
  localparam logic [HASH_W-1:0] RECIP =
    HASH_W'((PROD_W'(1) << HASH_W) / PROD_W'(BUCKETS));

  typedef enum logic [2:0] {H_IDLE, H_BYTES, H_QUOT, H_REM, H_FIX} hstate_t;

  hstate_t                        state_r, state_nxt;
  logic [HASH_W-1:0]              h_r, h_nxt;
  logic [LEN_W-1:0]               idx_r, idx_nxt;
  logic [LEN_W-1:0]               len_r, len_nxt;
  logic [HASH_W-1:0]              quot_r, quot_nxt;
  logic [RW-1:0]                  part_r, part_nxt;
  logic [BKT_W-1:0]               rem_r, rem_nxt;
  logic                           done_r, done_nxt;

  logic [KEY_BYTES-1:0][BYTE_W-1:0] key_bytes;
  logic [BYTE_W-1:0]                cur_byte;
  logic [PROD_W-1:0]                quot_prod;
  logic [HASH_W-1:0]                back_prod;
  logic [HASH_W-1:0]                part_diff;
  logic [RW-1:0]                    part_less;

  assign key_bytes = {key_high, key_low};
  assign cur_byte  = key_bytes[idx_r[$clog2(KEY_BYTES)-1:0]];

  // h - q * BUCKETS lands in [0, 2 * BUCKETS), so its low RW bits are exact
  assign quot_prod = PROD_W'(h_r) * PROD_W'(RECIP);
  assign back_prod = quot_r * HASH_W'(BUCKETS);
  assign part_diff = h_r - back_prod;
  assign part_less = part_r - RW'(BUCKETS);

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    quot_nxt  = quot_r;
    part_nxt  = part_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          h_nxt     = HASH_SEED;
          idx_nxt   = '0;
          len_nxt   = key_len;
          state_nxt = (key_len == '0) ? H_QUOT : H_BYTES;
        end
      end
      H_BYTES: begin
        // h * 33 + byte, wrapping at 32 bits
        h_nxt   = (h_r << 5) + h_r + HASH_W'(cur_byte);
        idx_nxt = idx_r + LEN_W'(1);
        if (idx_nxt == len_r) begin
          state_nxt = H_QUOT;
        end
      end
      H_QUOT: begin
        quot_nxt  = quot_prod[PROD_W-1:HASH_W];
        state_nxt = H_REM;
      end
      H_REM: begin
        part_nxt  = part_diff[RW-1:0];
        state_nxt = H_FIX;
      end
      H_FIX: begin
        rem_nxt   = (part_r >= RW'(BUCKETS)) ? part_less[BKT_W-1:0] : part_r[BKT_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = H_IDLE;
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    h_r    <= h_nxt;
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
    quot_r <= quot_nxt;
    part_r <= part_nxt;
    rem_r  <= rem_nxt;
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

`default_nettype wire

>>> hdl/chained_string_hash_table_top.sv
// Top level of the chained string hash table: request sequencer, slot and
// fill memories, result register. Depends on chst_pkg, chst_if, chst_ram, chst_hash.
`default_nettype none

// A request carries a key of up to MAX_KEY_BYTES bytes and a kind (insert,
// search, delete). The block takes one request at a time; in_req.ready is high
// only while the sequencer is idle. A request runs through the djb2 byte loop,
// the reciprocal-multiply remainder that reduces the hash to a bucket, the
// hand-over of the bucket, a read of the bucket fill count and the action on
// it, and for search or delete a read of the slot memory and a compare for
// each slot examined; then the result register is loaded and the sequencer
// goes back to idle to take the next request. The result sits in an output
// register, so the next request is taken while a result still waits for
// out_rsp.ready; only a second finished result stalls behind it. After reset
// the block sweeps the bucket fill memory to zero, one bucket per cycle, and
// takes no request until that is done. Slots are never cleared: only slots
// below a bucket's fill count are read. Deleted slots become tombstones that
// keep their place and never match again.
module chained_string_hash_table_top #(
  parameter int BUCKETS       = 1024,
  parameter int SLOTS         = 4,
  parameter int MAX_KEY_BYTES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chst_req_if.sink   in_req,
  chst_rsp_if.source out_rsp
);

  import chst_pkg::*;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int ADDR_W = $clog2(BUCKETS * SLOTS);
  localparam int EXT_W  = (BKT_W > BKT_OUT_W) ? BKT_W : BKT_OUT_W;

  typedef struct packed {
    logic             dead;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_FILL_RD, S_FILL_GOT, S_SLOT_RD, S_SLOT_CMP, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [KEY_W-1:0]        key_lo_r, key_lo_nxt;
  logic [KEY_W-1:0]        key_hi_r, key_hi_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [BKT_W-1:0]        bkt_r, bkt_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [FILL_W-1:0]       slot_r, slot_nxt;
  logic                    found_r, found_nxt;
  logic                    stored_r, stored_nxt;
  logic                    full_r, full_nxt;
  logic [LEN_W-1:0]        longest_len_r, longest_len_nxt;
  logic [BKT_OUT_W-1:0]    longest_bkt_r, longest_bkt_nxt;
  logic [BKT_OUT_W-1:0]    last_bkt_r, last_bkt_nxt;
  logic [BKT_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    o_found_r, o_found_nxt;
  logic                    o_stored_r, o_stored_nxt;
  logic                    o_full_r, o_full_nxt;
  logic [BKT_OUT_W-1:0]    o_bkt_r, o_bkt_nxt;
  logic [LEN_W-1:0]        o_longest_len_r, o_longest_len_nxt;
  logic [BKT_OUT_W-1:0]    o_longest_bkt_r, o_longest_bkt_nxt;
  logic [BKT_OUT_W-1:0]    o_last_bkt_r, o_last_bkt_nxt;

  // request side
  logic                              in_accept;
  logic [LEN_W-1:0]                  in_len_sat;
  logic [KEY_BYTES-1:0][BYTE_W-1:0]  in_bytes, in_bytes_masked;

  // hash unit
  logic                    hash_done;
  logic [BKT_W-1:0]        hash_bkt;

  // memories
  logic                    fill_we;
  logic [BKT_W-1:0]        fill_waddr, fill_raddr;
  logic [FILL_W-1:0]       fill_wdata, fill_rdata, fill_sat;
  logic                    slot_we;
  logic [ADDR_W-1:0]       slot_waddr, slot_raddr;
  slot_t                   slot_wdata, slot_rdata;

  logic [EXT_W-1:0]        bkt_ext;
  logic [BKT_OUT_W-1:0]    bkt_out;
  logic                    slot_match;
  logic [FILL_W-1:0]       slot_inc;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                  input logic [FILL_W-1:0] s);
    slot_addr = ADDR_W'(b) * ADDR_W'(SLOTS) + ADDR_W'(s);
  endfunction

  // Accept only while idle; saturate the length and zero bytes past it.
  assign in_accept = in_req.valid && (state_r == S_IDLE);
  assign in_len_sat = (in_req.key_length > LEN_W'(MAX_KEY_BYTES)) ?
                      LEN_W'(MAX_KEY_BYTES) : in_req.key_length;
  assign in_bytes = {in_req.key_high, in_req.key_low};

  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      in_bytes_masked[i] = (LEN_W'(i) < in_len_sat) ? in_bytes[i] : '0;
    end
  end

  // The hash unit latches the length at start and reads the held key
  // registers during its whole run.
  chst_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .key_low  (key_lo_r),
    .key_high (key_hi_r),
    .key_len  (in_len_sat),
    .done     (hash_done),
    .bucket   (hash_bkt)
  );

  chst_ram #(.WIDTH(FILL_W), .DEPTH(BUCKETS)) u_fill_ram (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_waddr),
    .wr_data (fill_wdata),
    .rd_addr (fill_raddr),
    .rd_data (fill_rdata)
  );

  chst_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKETS * SLOTS)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  assign fill_sat = (fill_rdata > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : fill_rdata;
  assign bkt_ext  = EXT_W'(bkt_r);
  assign bkt_out  = bkt_ext[BKT_OUT_W-1:0];
  assign slot_inc = slot_r + FILL_W'(1);

  // A live slot matches on length and both key words.
  assign slot_match = !slot_rdata.dead && (slot_rdata.len == len_r) &&
                      (slot_rdata.lo == key_lo_r) && (slot_rdata.hi == key_hi_r);

  assign fill_raddr = bkt_r;
  assign slot_raddr = slot_addr(bkt_r, slot_r);

  always_comb begin
    state_nxt         = state_r;
    kind_nxt          = kind_r;
    key_lo_nxt        = key_lo_r;
    key_hi_nxt        = key_hi_r;
    len_nxt           = len_r;
    bkt_nxt           = bkt_r;
    fill_nxt          = fill_r;
    slot_nxt          = slot_r;
    found_nxt         = found_r;
    stored_nxt        = stored_r;
    full_nxt          = full_r;
    longest_len_nxt   = longest_len_r;
    longest_bkt_nxt   = longest_bkt_r;
    last_bkt_nxt      = last_bkt_r;
    clr_addr_nxt      = clr_addr_r;
    out_valid_nxt     = out_valid_r;
    o_found_nxt       = o_found_r;
    o_stored_nxt      = o_stored_r;
    o_full_nxt        = o_full_r;
    o_bkt_nxt         = o_bkt_r;
    o_longest_len_nxt = o_longest_len_r;
    o_longest_bkt_nxt = o_longest_bkt_r;
    o_last_bkt_nxt    = o_last_bkt_r;

    fill_we    = 1'b0;
    fill_waddr = bkt_r;
    fill_wdata = '0;
    slot_we    = 1'b0;
    slot_waddr = slot_addr(bkt_r, slot_r);
    slot_wdata = slot_rdata;

    // drop the result once the consumer takes it
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // sweep bucket fill counts to zero after reset
        fill_we      = 1'b1;
        fill_waddr   = clr_addr_r;
        fill_wdata   = '0;
        clr_addr_nxt = clr_addr_r + BKT_W'(1);
        if (clr_addr_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          kind_nxt   = in_req.kind;
          key_lo_nxt = in_bytes_masked[KEY_BYTES/2-1:0];
          key_hi_nxt = in_bytes_masked[KEY_BYTES-1:KEY_BYTES/2];
          len_nxt    = in_len_sat;
          found_nxt  = 1'b0;
          stored_nxt = 1'b0;
          full_nxt   = 1'b0;
          slot_nxt   = '0;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bkt_nxt   = hash_bkt;
          state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        // fill count read is in flight
        state_nxt = S_FILL_GOT;
      end
      S_FILL_GOT: begin
        fill_nxt  = fill_sat;
        state_nxt = S_DONE;
        case (kind_r)
          KIND_INSERT: begin
            if (fill_sat >= FILL_W'(SLOTS)) begin
              full_nxt = 1'b1;
            end else begin
              slot_we         = 1'b1;
              slot_waddr      = slot_addr(bkt_r, fill_sat);
              slot_wdata.dead = 1'b0;
              slot_wdata.len  = len_r;
              slot_wdata.hi   = key_hi_r;
              slot_wdata.lo   = key_lo_r;
              fill_we         = 1'b1;
              fill_waddr      = bkt_r;
              fill_wdata      = fill_sat + FILL_W'(1);
              stored_nxt      = 1'b1;
              if (longest_len_r < len_r) begin
                longest_len_nxt = len_r;
                longest_bkt_nxt = bkt_out;
              end
              last_bkt_nxt    = bkt_out;
            end
          end
          KIND_SEARCH, KIND_DELETE: begin
            if (fill_sat != '0) begin
              state_nxt = S_SLOT_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SLOT_RD: begin
        // slot read is in flight
        state_nxt = S_SLOT_CMP;
      end
      S_SLOT_CMP: begin
        if (slot_match) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
          if (kind_r == KIND_DELETE) begin
            // leave a tombstone in place
            slot_we         = 1'b1;
            slot_wdata.dead = 1'b1;
          end
        end else if (slot_inc == fill_r) begin
          state_nxt = S_DONE;
        end else begin
          slot_nxt  = slot_inc;
          state_nxt = S_SLOT_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt     = 1'b1;
          o_found_nxt       = found_r;
          o_stored_nxt      = stored_r;
          o_full_nxt        = full_r;
          o_bkt_nxt         = bkt_out;
          o_longest_len_nxt = longest_len_r;
          o_longest_bkt_nxt = longest_bkt_r;
          o_last_bkt_nxt    = last_bkt_r;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
      longest_len_r <= '0;
      longest_bkt_r <= '0;
      last_bkt_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      out_valid_r   <= out_valid_nxt;
      longest_len_r <= longest_len_nxt;
      longest_bkt_r <= longest_bkt_nxt;
      last_bkt_r    <= last_bkt_nxt;
    end
    kind_r          <= kind_nxt;
    key_lo_r        <= key_lo_nxt;
    key_hi_r        <= key_hi_nxt;
    len_r           <= len_nxt;
    bkt_r           <= bkt_nxt;
    fill_r          <= fill_nxt;
    slot_r          <= slot_nxt;
    found_r         <= found_nxt;
    stored_r        <= stored_nxt;
    full_r          <= full_nxt;
    o_found_r       <= o_found_nxt;
    o_stored_r      <= o_stored_nxt;
    o_full_r        <= o_full_nxt;
    o_bkt_r         <= o_bkt_nxt;
    o_longest_len_r <= o_longest_len_nxt;
    o_longest_bkt_r <= o_longest_bkt_nxt;
    o_last_bkt_r    <= o_last_bkt_nxt;
  end

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.found          = o_found_r;
  assign out_rsp.stored         = o_stored_r;
  assign out_rsp.bucket_full    = o_full_r;
  assign out_rsp.bucket         = o_bkt_r;
  assign out_rsp.longest_length = o_longest_len_r;
  assign out_rsp.longest_bucket = o_longest_bkt_r;
  assign out_rsp.last_bucket    = o_last_bkt_r;

endmodule

`default_nettype wire
